// ===== hw/rtl/box_blur_3x3_stream_macros.svh =====
// assertion macros for the box blur stream block
// used by the checker; needs no package
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH

// same-cycle implication, off during reset
`define BB3_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BB3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// checked through reset as well
`define BB3_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bb3_pkg.sv =====
// shared types, codes and constants of the 3x3 box blur stream
// no dependencies
package bb3_pkg;

    // register indexes of the write port
    localparam int unsigned CFG_AW = 1;
    localparam int unsigned CFG_DW = 11;
    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;

    // input word kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // output queue
    localparam int unsigned OFIFO_AW    = 3;
    localparam int unsigned OFIFO_DEPTH = 2 ** OFIFO_AW;

    // reciprocals scaled by 2^14, exact over the sums that can occur
    localparam int unsigned RECIP_SHIFT = 14;
    localparam logic [14:0] RECIP_ONE   = 15'd16384;
    localparam logic [14:0] RECIP_3     = 15'd5462;
    localparam logic [14:0] RECIP_9     = 15'd1821;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // which window columns / rows lie inside the frame, and the frame-end flag
    typedef struct packed {
        logic [2:0] col_ok;
        logic [2:0] row_ok;
        logic       last;
    } win_tag_t;

    typedef struct packed {
        logic last;
        pix_t pix;
    } res_t;

    // round-half-up mean: (2*sum + cnt) / (2*cnt), cnt in {1,2,3,4,6,9}
    function automatic logic [7:0] mean_round(input logic [11:0] sum, input logic [3:0] cnt);
        logic [12:0] x;
        logic [12:0] y;
        logic [14:0] m;
        logic [27:0] prod;
        x = {sum, 1'b0} + 13'(cnt);
        y = x >> 1;
        m = RECIP_ONE;
        case (cnt)
            4'd1: begin y = x >> 1; m = RECIP_ONE; end
            4'd2: begin y = x >> 2; m = RECIP_ONE; end
            4'd4: begin y = x >> 3; m = RECIP_ONE; end
            4'd3: begin y = x >> 1; m = RECIP_3; end
            4'd6: begin y = x >> 2; m = RECIP_3; end
            4'd9: begin y = x >> 1; m = RECIP_9; end
            default: begin y = '0; m = RECIP_ONE; end
        endcase
        prod = 28'(y) * 28'(m);
        return 8'(prod >> RECIP_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_stream.sv =====
// 3x3 box blur on an RGB pixel stream; one word per clock while the queue has room.
// output pixel k is the result of input word k+width+1; it reaches m_ through the
// line store read, window and sum registers, the reciprocal multiply and the queue.
// the rate follows from one read-modify-write of each line store per word.
// aresetn (sync, active low) clears positions, pipeline and output queue and sets
// both dimensions to 1024; line store contents are kept and need no clearing.
module box_blur_3x3_stream
    import bb3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // in_red, in_green, in_blue
    input  logic              s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // out_red, out_green, out_blue
    output logic              m_tlast,   // frame_end
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);
    localparam int unsigned W_RESET = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int unsigned H_RESET = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [WW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic          done;
    logic          step;
    logic          emit;
    logic          col_zero;
    logic          col_last;
    logic [RW-1:0] ctr_row;
    win_tag_t      tag;
    pix_t          pix_in;

    logic          s1_valid_reg;
    logic          s1_emit_reg;
    win_tag_t      s1_tag_reg;
    logic          s2_valid_reg;
    win_tag_t      s2_tag_reg;
    pix_t [2:0][2:0] win_reg;

    pix_t          up_q;
    pix_t          mid_q;
    pix_t          pix_q;
    logic          res_valid;
    res_t          res;

    res_t                ofifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg;
    logic [OFIFO_AW-1:0] rd_ptr_reg;
    logic [OFIFO_AW:0]   cnt_reg;
    logic [1:0]          inflight;
    logic                pop;

    // ---------------- configuration
    always_comb begin
        cfg_w = (cfg_wdata == '0) ? WW'(1)
              : (32'(cfg_wdata) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_wdata);
        cfg_h = (cfg_wdata == '0) ? HW'(1)
              : (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(W_RESET);
            height_reg <= HW'(H_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  width_reg  <= cfg_w;
                REG_FRAME_HEIGHT: height_reg <= cfg_h;
                default: ;
            endcase
        end
    end

    // ---------------- input position and window tags
    assign pop      = m_tvalid && m_tready;
    assign inflight = 2'(s1_emit_reg) + 2'(s2_valid_reg) + 2'(res_valid);
    assign s_tready = (5'(cnt_reg) + 5'(inflight)) < 5'(OFIFO_DEPTH);

    always_comb begin
        done     = row_reg >= RW'(height_reg);
        // once the frame is in, every word pushes a virtual pixel through
        step     = s_tvalid && s_tready && (done || s_tuser == OP_PIXEL);
        pix_in   = done ? '0 : pix_t'(s_tdata);
        col_zero = (col_reg == '0);
        col_last = (WW'(col_reg) + WW'(1)) == width_reg;
        emit     = (row_reg >= RW'(2)) || (row_reg == RW'(1) && !col_zero);
        // center row of the finished neighborhood
        ctr_row  = col_zero ? row_reg - RW'(2) : row_reg - RW'(1);

        tag.col_ok[0] = col_zero ? (width_reg > WW'(1)) : (WW'(col_reg) > WW'(1));
        tag.col_ok[1] = 1'b1;
        tag.col_ok[2] = !col_zero;
        tag.row_ok[0] = ctr_row != '0;
        tag.row_ok[1] = 1'b1;
        tag.row_ok[2] = (ctr_row + RW'(1)) < RW'(height_reg);
        tag.last      = emit && col_zero && (row_reg == RW'(height_reg) + RW'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (step) begin
            if (tag.last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_last) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores and window
    bb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (step),
        .addr    (col_reg),
        .pix_in  (pix_in),
        .up_q    (up_q),
        .mid_q   (mid_q),
        .pix_q   (pix_q)
    );

    always_ff @(posedge aclk) begin
        if (step) begin
            s1_tag_reg <= tag;
        end
        s2_tag_reg <= s1_tag_reg;
        if (s1_valid_reg) begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= up_q;
            win_reg[2][1] <= mid_q;
            win_reg[2][2] <= pix_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= step;
            s1_emit_reg  <= step && emit;
            s2_valid_reg <= s1_emit_reg;
        end
    end

    bb3_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .win       (win_reg),
        .tag       (s2_tag_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------- output queue
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            ofifo[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (res_valid) begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            end
            cnt_reg <= cnt_reg + (OFIFO_AW+1)'(res_valid) - (OFIFO_AW+1)'(pop);
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = ofifo[rd_ptr_reg].pix;
    assign m_tlast  = ofifo[rd_ptr_reg].last;

endmodule

// ===== hw/rtl/bb3_line_store.sv =====
// two line stores (upper and middle row) with read-modify-write per pixel
// depends on bb3_pkg
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  pix_t          pix_in,
    output pix_t          up_q,
    output pix_t          mid_q,
    output pix_t          pix_q
);

    pix_t upper_mem  [DEPTH];
    pix_t middle_mem [DEPTH];

    pix_t          up_rd_reg;
    pix_t          mid_rd_reg;
    pix_t          fwd_up_reg;
    pix_t          fwd_mid_reg;
    logic          fwd_reg;
    pix_t          pix_reg;
    logic [AW-1:0] addr_reg;
    logic          wr_pend_reg;

    assign up_q  = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_q = fwd_reg ? fwd_mid_reg : mid_rd_reg;
    assign pix_q = pix_reg;

    // write back in the cycle after the read, the middle row moves up
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            upper_mem[addr_reg]  <= mid_q;
            middle_mem[addr_reg] <= pix_reg;
        end
        if (rd_en) begin
            up_rd_reg   <= upper_mem[addr];
            mid_rd_reg  <= middle_mem[addr];
            // read meets the write-back of the previous word at the same column
            fwd_reg     <= wr_pend_reg && (addr_reg == addr);
            fwd_up_reg  <= mid_q;
            fwd_mid_reg <= pix_reg;
            pix_reg     <= pix_in;
            addr_reg    <= addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= rd_en;
        end
    end

endmodule

// ===== hw/rtl/bb3_mean.sv =====
// masked 3x3 sums and rounded division by the neighbor count
// depends on bb3_pkg
module bb3_mean
    import bb3_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  pix_t [2:0][2:0] win,
    input  win_tag_t        tag,
    output logic            res_valid,
    output res_t            res
);

    logic [11:0] sum_r;
    logic [11:0] sum_g;
    logic [11:0] sum_b;
    logic [1:0]  ncol;
    logic [1:0]  nrow;

    logic [11:0] sum_r_reg;
    logic [11:0] sum_g_reg;
    logic [11:0] sum_b_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic        valid_reg;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (tag.col_ok[k] && tag.row_ok[j]) begin
                    sum_r = sum_r + 12'(win[k][j].red);
                    sum_g = sum_g + 12'(win[k][j].green);
                    sum_b = sum_b + 12'(win[k][j].blue);
                end
            end
        end
        ncol = 2'(tag.col_ok[0]) + 2'(tag.col_ok[1]) + 2'(tag.col_ok[2]);
        nrow = 2'(tag.row_ok[0]) + 2'(tag.row_ok[1]) + 2'(tag.row_ok[2]);
    end

    always_ff @(posedge aclk) begin
        sum_r_reg <= sum_r;
        sum_g_reg <= sum_g;
        sum_b_reg <= sum_b;
        cnt_reg   <= 4'(ncol) * 4'(nrow);
        last_reg  <= tag.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    assign res_valid     = valid_reg;
    assign res.last      = last_reg;
    assign res.pix.red   = mean_round(sum_r_reg, cnt_reg);
    assign res.pix.green = mean_round(sum_g_reg, cnt_reg);
    assign res.pix.blue  = mean_round(sum_b_reg, cnt_reg);

endmodule

// ===== hw/rtl/bb3_checker.sv =====
// port-level checks of the box blur stream, bound to the top level
// depends on box_blur_3x3_stream_macros.svh
`include "box_blur_3x3_stream_macros.svh"

module bb3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result word keeps its contents
    `BB3_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast),
                     "result word changed while stalled")

    // reset empties the output side
    `BB3_ASSERT_ALWAYS(a_reset_empty, aclk, $past(!aresetn), !m_tvalid,
                       "result pending right after reset")

    // a rising result valid traces back to an input word taken through the pipeline registers
    `BB3_ASSERT_SAME(a_out_origin, aclk, aresetn, $rose(m_tvalid),
                     $past(s_tvalid && s_tready, 4),
                     "result without a word taken four cycles before")

    // input is never held off while no result waits
    `BB3_ASSERT_SAME(a_ready_empty, aclk, aresetn, !m_tvalid, s_tready,
                     "input stalled with empty output")

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (.*);

// ===== tb/sv/box_blur_3x3_stream_tb.sv =====
// self-checking testbench for box_blur_3x3_stream: random RGB frames, stalls on both sides
// depends on bb3_pkg and the box_blur_3x3_stream rtl
`timescale 1ns / 100ps

module box_blur_3x3_stream_tb;
    import bb3_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam real CLK_PERIOD   = 4.0;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_WORDS    = 240;

    typedef enum {FILL_MIXED, FILL_EXTREME} fill_t;

    // keeps its own copy of the line stores and window and predicts each blurred pixel
    class blur_scoreboard;
        int   width_px;
        int   height_px;
        pix_t upper_row [MAX_W];
        pix_t middle_row [MAX_W];
        pix_t win [3][3];  // [column oldest..newest][row oldest..newest]
        int   in_col;
        int   in_row;
        int   out_cnt;
        res_t blurred_due [$];
        int   mismatches;

        function new();
            width_px = MAX_W;
            height_px = MAX_H;
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_cnt = 0;
        endfunction

        function bit frame_busy();
            return in_row != 0 || in_col != 0 || out_cnt != 0;
        endfunction

        function void set_dim(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            int dim;
            dim = val;
            if (dim == 0) dim = 1;
            if (idx == REG_FRAME_WIDTH) begin
                width_px = (dim > MAX_W) ? MAX_W : dim;
                restart();
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_px = (dim > MAX_H) ? MAX_H : dim;
                restart();
            end
        endfunction

        function void take_word(logic op, pix_t px);
            pix_t   cur;
            pix_t   up_px;
            pix_t   mid_px;
            pix_t   v;
            int     col;
            int     row;
            int     cnt;
            int     sr;
            int     sg;
            int     sb;
            int     crow;
            int     ccol;
            int     ic;
            int     ir;
            longint total;
            longint pos;
            res_t   r;
            total = longint'(width_px) * height_px;
            if (in_row < height_px) begin
                if (op == OP_DRAIN) return;  // drain while pixels still due: no effect
                cur = px;
            end else begin
                cur = '0;  // below the frame, always masked
            end
            col = in_col;
            row = in_row;
            if (col >= width_px) col = 0;
            up_px = upper_row[col];
            mid_px = middle_row[col];
            upper_row[col] = mid_px;
            middle_row[col] = cur;
            for (int j = 0; j < 3; j++) begin
                win[0][j] = win[1][j];
                win[1][j] = win[2][j];
            end
            win[2][0] = up_px;
            win[2][1] = mid_px;
            win[2][2] = cur;

            pos = longint'(row) * width_px + col;
            if (col + 1 >= width_px) begin
                in_col = 0;
                in_row = row + 1;
            end else begin
                in_col = col + 1;
            end
            if (pos < width_px + 1 || out_cnt >= total) return;

            // at column 0 the centre is the last pixel of the row two back
            if (col >= 1) begin
                crow = row - 1;
                ccol = col - 1;
            end else begin
                crow = row - 2;
                ccol = width_px - 1;
            end
            sr = 0;
            sg = 0;
            sb = 0;
            cnt = 0;
            for (int k = 0; k < 3; k++) begin
                ic = ccol - 1 + k;
                if ((col == 0 && k == 2) || ic < 0 || ic >= width_px) continue;
                for (int j = 0; j < 3; j++) begin
                    ir = crow - 1 + j;
                    if (ir < 0 || ir >= height_px) continue;
                    v = win[k][j];
                    sr += v.red;
                    sg += v.green;
                    sb += v.blue;
                    cnt++;
                end
            end
            r.pix.red = 8'((2 * sr + cnt) / (2 * cnt));
            r.pix.green = 8'((2 * sg + cnt) / (2 * cnt));
            r.pix.blue = 8'((2 * sb + cnt) / (2 * cnt));
            out_cnt++;
            r.last = (out_cnt >= total);
            if (r.last) restart();
            blurred_due.push_back(r);
        endfunction

        function void check_pixel(pix_t got, logic got_last);
            res_t e;
            if (blurred_due.size() == 0) begin
                $error("unexpected output word: red %0d green %0d blue %0d frame_end %0b",
                       got.red, got.green, got.blue, got_last);
                mismatches++;
                return;
            end
            e = blurred_due.pop_front();
            if (got.red !== e.pix.red) begin
                $error("out_red: expected %0d, got %0d", e.pix.red, got.red);
                mismatches++;
            end
            if (got.green !== e.pix.green) begin
                $error("out_green: expected %0d, got %0d", e.pix.green, got.green);
                mismatches++;
            end
            if (got.blue !== e.pix.blue) begin
                $error("out_blue: expected %0d, got %0d", e.pix.blue, got.blue);
                mismatches++;
            end
            if (got_last !== e.last) begin
                $error("frame_end: expected %0b, got %0b", e.last, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // in_red, in_green, in_blue
    logic              s_tuser;   // op
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // out_red, out_green, out_blue
    logic              m_tlast;   // frame_end
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    blur_scoreboard board = new();
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req = 1'b0;

    box_blur_3x3_stream #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic pix_t make_pixel(fill_t fill, int idx);
        pix_t px;
        int   mode;
        mode = $urandom_range(9);
        if (fill == FILL_EXTREME && idx == 0) begin
            px = '0;
        end else if (fill == FILL_EXTREME && idx == 1) begin
            px = '1;
        end else if (fill == FILL_EXTREME || mode >= 8) begin
            px.red = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        end else if (mode >= 6) begin
            // small values hit the half-way rounding cases
            px.red = 8'($urandom_range(3));
            px.green = 8'($urandom_range(3));
            px.blue = 8'($urandom_range(3));
        end else begin
            px = 24'($urandom);
        end
        return px;
    endfunction

    task automatic send_word(input logic op, input pix_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        board.take_word(op, px);
    endtask

    // stop offering words until every predicted pixel is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.blurred_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_AW-1:0] idx, input int unsigned val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DW'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_dim(idx, CFG_DW'(val));
    endtask

    // npix pixels with stray drains mixed in; with finish set, the tail is flushed
    // by drains and dummy pixels until the frame_end word is predicted
    task automatic feed_frame(input int npix, input fill_t fill, input bit finish,
                              input int hold_at, input int pause_at, output int sent);
        sent = 0;
        for (int i = 0; i < npix; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            if (i == pause_at) settle();
            if ((fill == FILL_EXTREME && i == 4) || $urandom_range(19) == 0)
                send_word(OP_DRAIN, make_pixel(FILL_MIXED, i));
            send_word(OP_PIXEL, make_pixel(fill, i));
            sent++;
        end
        while (finish && board.frame_busy()) begin
            send_word(($urandom_range(3) == 0) ? OP_PIXEL : OP_DRAIN,
                      make_pixel(FILL_MIXED, 2));
            sent++;
        end
    endtask

    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tlast);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("box_blur_3x3_stream_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int w;
        int h;
        int n;
        int rand_words;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_PIXEL;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 18;
        snk_idle_pct = 75;

        // 3x3 frame: corners, edges and centre with 0 / 255 content
        write_cfg(REG_FRAME_WIDTH, 3);
        write_cfg(REG_FRAME_HEIGHT, 3);
        feed_frame(9, FILL_EXTREME, 1'b1, -1, -1, sent);
        // zero dimensions are taken as one: single pixel frame
        write_cfg(REG_FRAME_WIDTH, 0);
        write_cfg(REG_FRAME_HEIGHT, 0);
        feed_frame(1, FILL_EXTREME, 1'b1, -1, -1, sent);
        write_cfg(REG_FRAME_WIDTH, 2);
        feed_frame(2, FILL_EXTREME, 1'b1, -1, -1, sent);

        // oversize width clamps to the max; abort sixteen pixels into the second row
        write_cfg(REG_FRAME_WIDTH, 11'h7FF);
        write_cfg(REG_FRAME_HEIGHT, 2);
        feed_frame(MAX_W + 16, FILL_MIXED, 1'b0, -1, -1, sent);

        // receiver holds off long enough to back the block up, later a full pause
        write_cfg(REG_FRAME_WIDTH, 24);
        write_cfg(REG_FRAME_HEIGHT, 6);
        feed_frame(144, FILL_MIXED, 1'b1, 40, 110, sent);

        rand_words = 0;
        while (rand_words < RAND_WORDS) begin
            if (rand_words < RAND_WORDS / 3) begin
                src_idle_pct = 18;
                snk_idle_pct = 75;
            end else if (rand_words < 2 * RAND_WORDS / 3) begin
                src_idle_pct = 75;
                snk_idle_pct = 18;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(5) == 0) begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 4);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            write_cfg(REG_FRAME_WIDTH, w);
            write_cfg(REG_FRAME_HEIGHT, h);
            n = w * h;
            // now and then a frame is cut short by the next register write
            if ($urandom_range(9) == 0)
                feed_frame($urandom_range(1, n), FILL_MIXED, 1'b0, -1, -1, sent);
            else
                feed_frame(n, FILL_MIXED, 1'b1, -1, -1, sent);
            rand_words += sent;
        end

        settle();
        if (board.mismatches == 0) begin
            $display("box_blur_3x3_stream_tb: done, clean");
        end else begin
            $display("box_blur_3x3_stream_tb: done, errors");
        end
        $finish;
    end

endmodule
